// File: rtl/core/ptm_pkg.sv
// Shared types and constants of the IOMMU page table manager.
`timescale 1ns / 1ps
`default_nettype none
package ptm_pkg;

  localparam int unsigned TableEntriesDef  = 1024;
  localparam int unsigned MaxRetryLevelDef = 4;

  localparam int unsigned OpW    = 3;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned CntW   = 11;
  localparam int unsigned PageW  = 24;
  localparam int unsigned StatW  = 2;
  localparam int unsigned WordW  = 32;
  localparam int unsigned ActW   = 2;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 40;

  localparam logic [WordW-1:0] ValidBit = 32'h8000_0000;

  localparam logic [OpW-1:0] OP_MAP    = 3'd0;
  localparam logic [OpW-1:0] OP_UNMAP  = 3'd1;
  localparam logic [OpW-1:0] OP_FLUSH  = 3'd2;
  localparam logic [OpW-1:0] OP_SAMPLE = 3'd3;
  localparam logic [OpW-1:0] OP_READ   = 3'd4;

  localparam logic [StatW-1:0] ST_OK      = 2'd0;
  localparam logic [StatW-1:0] ST_RANGE   = 2'd1;
  localparam logic [StatW-1:0] ST_TIMEOUT = 2'd2;

  localparam logic [ActW-1:0] ACT_NONE    = 2'd0;
  localparam logic [ActW-1:0] ACT_SET     = 2'd1;
  localparam logic [ActW-1:0] ACT_CLR_SET = 2'd2;

  typedef enum logic [2:0] {
    K_MAP    = 3'd0,
    K_UNMAP  = 3'd1,
    K_FLUSH  = 3'd2,
    K_SAMPLE = 3'd3,
    K_READ   = 3'd4,
    K_NOP    = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic              range_err;
    logic [IdxW-1:0]   index;
    logic [CntW-1:0]   count;
    logic [PageW-1:0]  page;
    logic              busy;
  } cmd_t;

  typedef struct packed {
    logic              waiting;
    logic [ActW-1:0]   action;
    logic [WordW-1:0]  word;
    logic [StatW-1:0]  status;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/core/iommu_page_table_manager_top.sv
// Flush, sample and error words go straight to the output register; reads pass the registered
// RAM read; map/unmap of count entries writes one table entry per cycle through the RAM port.
// The back end takes a new command only after the last one has loaded its output word.
// A two-word command queue lets the input side keep accepting while the back end works.
// Reset (async, active low) clears control, flush state, dirty flag and the spare page register;
// table contents are undefined until written, so no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none
module iommu_page_table_manager_top #(
  parameter int unsigned TABLE_ENTRIES   = ptm_pkg::TableEntriesDef,
  parameter int unsigned MAX_RETRY_LEVEL = ptm_pkg::MaxRetryLevelDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ptm_pkg::PageW-1:0]     cfg_wdata_i,   // empty_page
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // index[9:0], count[20:10], page_number[44:21], flush_busy[45], zero pad
  input  wire logic [ptm_pkg::InDataW-1:0]   s_axis_tdata,
  input  wire logic [ptm_pkg::OpW-1:0]       s_axis_tuser,  // op[2:0]
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // status[1:0], entry_word[33:2], control_action[35:34], flush_waiting[36], zero pad
  output logic [ptm_pkg::OutDataW-1:0]       m_axis_tdata
);
  import ptm_pkg::*;

  logic [PageW-1:0] empty_page_q;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_pop;
  res_t             res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_page_q <= '0;
    end else if (cfg_we_i) begin
      empty_page_q <= cfg_wdata_i;
    end
  end

  ptm_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  ptm_back #(
    .TABLE_ENTRIES  (TABLE_ENTRIES),
    .MAX_RETRY_LEVEL(MAX_RETRY_LEVEL)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_page_i(empty_page_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {3'b000, res.waiting, res.action, res.word, res.status};

  a_timeout_ends_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.status == ST_TIMEOUT) |-> !res.waiting)
    else $error("timeout reported while flush still waiting");

  a_action_needs_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.action != ACT_NONE) |-> res.waiting)
    else $error("flush bit action without a pending flush");

  a_word_only_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.word != '0) |-> (res.status == ST_OK && res.action == ACT_NONE))
    else $error("entry word alongside error or flush action");

  a_pop_when_queued : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

endmodule
`default_nettype wire

// File: rtl/core/ptm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ptm_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/ptm_front.sv
// Front end: accepts input words, classifies them and queues commands.
`timescale 1ns / 1ps
`default_nettype none
module ptm_front #(
  parameter int unsigned TABLE_ENTRIES = ptm_pkg::TableEntriesDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_tvalid_i,
  output logic                              s_tready_o,
  input  wire logic [ptm_pkg::InDataW-1:0]  s_tdata_i,
  input  wire logic [ptm_pkg::OpW-1:0]      s_tuser_i,
  output logic                              cmd_valid_o,
  output ptm_pkg::cmd_t                     cmd_o,
  input  wire logic                         cmd_pop_i
);
  import ptm_pkg::*;

  localparam logic [31:0] TableEnd = 32'(TABLE_ENTRIES);

  cmd_t        cmd_in;
  logic [31:0] idx_w;
  logic [31:0] end_w;
  logic        push;

  cmd_t        fifo_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  fill_q, fill_d;

  assign idx_w = 32'(s_tdata_i[9:0]);
  assign end_w = idx_w + 32'(s_tdata_i[20:10]);

  always_comb begin
    cmd_in.index     = s_tdata_i[9:0];
    cmd_in.count     = s_tdata_i[20:10];
    cmd_in.page      = s_tdata_i[44:21];
    cmd_in.busy      = s_tdata_i[45];
    cmd_in.range_err = 1'b0;
    unique case (s_tuser_i)
      OP_MAP: begin
        cmd_in.kind      = K_MAP;
        cmd_in.range_err = end_w > TableEnd;
      end
      OP_UNMAP: begin
        cmd_in.kind      = K_UNMAP;
        cmd_in.range_err = end_w > TableEnd;
      end
      OP_FLUSH:  cmd_in.kind = K_FLUSH;
      OP_SAMPLE: cmd_in.kind = K_SAMPLE;
      OP_READ: begin
        cmd_in.kind      = K_READ;
        cmd_in.range_err = idx_w >= TableEnd;
      end
      default:   cmd_in.kind = K_NOP;
    endcase
  end

  assign s_tready_o  = (fill_q != 2'd2);
  assign push        = s_tvalid_i && s_tready_o;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ cmd_pop_i;
    fill_d   = fill_q + 2'(push) - 2'(cmd_pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/ptm_back.sv
// Back end: table writes and reads, flush handshake and result register.
`timescale 1ns / 1ps
`default_nettype none
module ptm_back #(
  parameter int unsigned TABLE_ENTRIES   = ptm_pkg::TableEntriesDef,
  parameter int unsigned MAX_RETRY_LEVEL = ptm_pkg::MaxRetryLevelDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [ptm_pkg::PageW-1:0]  empty_page_i,
  input  wire logic                       cmd_valid_i,
  input  wire ptm_pkg::cmd_t              cmd_i,
  output logic                            cmd_pop_o,
  output logic                            m_tvalid_o,
  input  wire logic                       m_tready_i,
  output ptm_pkg::res_t                   res_o
);
  import ptm_pkg::*;

  localparam int unsigned AW  = $clog2(TABLE_ENTRIES);
  localparam int unsigned RLW = (MAX_RETRY_LEVEL > 0) ? $clog2(MAX_RETRY_LEVEL + 1) : 1;
  localparam int unsigned PCW = MAX_RETRY_LEVEL + 1;
  localparam logic [RLW-1:0] MaxLevel = RLW'(MAX_RETRY_LEVEL);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FILL = 3'b010,
    S_RESP = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [PageW-1:0] page_q, page_d;
  logic             step_q, step_d;
  logic             from_ram_q, from_ram_d;
  logic             dirty_q, dirty_d;
  logic             waiting_q, waiting_d;
  logic [RLW-1:0]   level_q, level_d;
  logic [PCW-1:0]   polls_q, polls_d;
  logic [PCW-1:0]   polls_inc;
  logic [PCW-1:0]   limit;
  logic             out_valid_q;
  res_t             out_q;
  res_t             res_d;
  logic             load;
  logic             out_free;
  logic [31:0]      idx_w;
  logic             ram_re;
  logic [PageW-1:0] ram_rdata;

  assign out_free  = !out_valid_q || m_tready_i;
  assign idx_w     = 32'(cmd_i.index);
  assign polls_inc = polls_q + PCW'(1);
  assign limit     = PCW'(1) << level_q;

  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    rem_d      = rem_q;
    page_d     = page_q;
    step_d     = step_q;
    from_ram_d = from_ram_q;
    dirty_d    = dirty_q;
    waiting_d  = waiting_q;
    level_d    = level_q;
    polls_d    = polls_q;
    cmd_pop_o  = 1'b0;
    ram_re     = 1'b0;
    load       = 1'b0;
    res_d.status  = ST_OK;
    res_d.word    = '0;
    res_d.action  = ACT_NONE;
    res_d.waiting = waiting_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          load      = 1'b1;
          unique case (cmd_i.kind)
            K_MAP, K_UNMAP: begin
              if (cmd_i.range_err) begin
                res_d.status = ST_RANGE;
              end else begin
                if (cmd_i.kind == K_MAP) begin
                  dirty_d = 1'b1;
                end
                if (cmd_i.count != '0) begin
                  load       = 1'b0;
                  state_d    = S_FILL;
                  addr_d     = idx_w[AW-1:0];
                  rem_d      = cmd_i.count;
                  step_d     = (cmd_i.kind == K_MAP);
                  page_d     = (cmd_i.kind == K_MAP) ? cmd_i.page : empty_page_i;
                  from_ram_d = 1'b0;
                end
              end
            end
            K_FLUSH: begin
              if (dirty_q) begin
                waiting_d    = 1'b1;
                level_d      = '0;
                polls_d      = '0;
                res_d.action = ACT_SET;
              end
              dirty_d = 1'b0;
            end
            K_SAMPLE: begin
              if (waiting_q) begin
                if (!cmd_i.busy) begin
                  waiting_d = 1'b0;
                  level_d   = '0;
                  polls_d   = '0;
                end else if (polls_inc == limit) begin
                  polls_d = '0;
                  if (level_q < MaxLevel) begin
                    level_d      = level_q + RLW'(1);
                    res_d.action = ACT_CLR_SET;
                  end else begin
                    waiting_d    = 1'b0;
                    level_d      = '0;
                    res_d.status = ST_TIMEOUT;
                  end
                end else begin
                  polls_d = polls_inc;
                end
              end
            end
            K_READ: begin
              if (cmd_i.range_err) begin
                res_d.status = ST_RANGE;
              end else begin
                load       = 1'b0;
                ram_re     = 1'b1;
                from_ram_d = 1'b1;
                state_d    = S_RESP;
              end
            end
            default: ;
          endcase
          res_d.waiting = waiting_d;
        end
      end
      S_FILL: begin
        addr_d = addr_q + AW'(1);
        rem_d  = rem_q - CntW'(1);
        page_d = page_q + PageW'(step_q);
        if (rem_q == CntW'(1)) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
          if (from_ram_q) begin
            res_d.word = ValidBit | WordW'(ram_rdata);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  ptm_ram #(
    .WIDTH(PageW),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (state_q == S_FILL),
    .waddr_i(addr_q),
    .wdata_i(page_q),
    .re_i   (ram_re),
    .raddr_i(idx_w[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    rem_q      <= rem_d;
    page_q     <= page_d;
    step_q     <= step_d;
    if (load) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      from_ram_q  <= 1'b0;
      dirty_q     <= 1'b0;
      waiting_q   <= 1'b0;
      level_q     <= '0;
      polls_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      from_ram_q <= from_ram_d;
      dirty_q    <= dirty_d;
      waiting_q  <= waiting_d;
      level_q    <= level_d;
      polls_q    <= polls_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign res_o      = out_q;

endmodule
`default_nettype wire
